/* src/dlf_pkg.sv */
// Shared types and constants for the directory entry listing formatter.
`default_nettype none
package dlf_pkg;

  // Width of the listing counters and of the extended compare path.
  localparam int CNT_W = 32;
  localparam int CMP_W = 64;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Most text bytes one entry can produce: 8 + '.' + 3 + '/' + newline.
  localparam int MAX_CHARS = 14;
  localparam int LEN_W = 4;
  localparam int IDX_W = 4;

  // Configuration register indexes.
  localparam logic REG_SKIP_BYTES      = 1'b0;
  localparam logic REG_BUFFER_CAPACITY = 1'b1;
  localparam logic [31:0] SKIP_BYTES_RESET      = 32'd0;
  localparam logic [31:0] BUFFER_CAPACITY_RESET = 32'd512;

  // Entry markers, attribute bits and characters.
  localparam logic [7:0] MARK_END       = 8'h00;
  localparam logic [7:0] MARK_DELETED   = 8'he5;
  localparam logic [7:0] ATTR_LONG_NAME = 8'h0f;
  localparam logic [7:0] ATTR_VOLUME    = 8'h08;
  localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_DOT       = 8'h2e;
  localparam logic [7:0] CHAR_SLASH     = 8'h2f;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_END  = 2'd1,
    KIND_FULL = 2'd2
  } dlf_kind_t;

  // One decoded entry: its text bytes in order and how many there are.
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [LEN_W-1:0]          len;
    logic                      is_end;
    logic                      start;
  } dlf_entry_t;

  // One result beat.
  typedef struct packed {
    dlf_kind_t   kind;
    logic [7:0]  text_byte;
    logic [31:0] byte_index;
    logic        last;
  } dlf_result_t;

endpackage
`default_nettype wire

/* src/dlf_decode.sv */
// Entry decode: filtering, blank trimming and packing of the text bytes.
`default_nettype none
module dlf_decode (
  input  wire logic              start_listing,
  input  wire logic [63:0]       name_base,
  input  wire logic [23:0]       name_ext,
  input  wire logic [7:0]        attributes,
  output dlf_pkg::dlf_entry_t    entry
);

  logic [7:0][7:0] base;
  logic [2:0][7:0] ext;
  logic [4:0]      base_len;
  logic [4:0]      ext_end;
  logic            has_ext;
  logic            is_dir;
  logic            skipped;
  logic [4:0]      ext_stop;
  logic [4:0]      dir_pos;
  logic [4:0]      nl_pos;

  assign base   = name_base;
  assign ext    = name_ext;
  assign is_dir = (attributes & dlf_pkg::ATTR_DIRECTORY) != 8'd0;

  // Deleted, long-name, volume and dot entries give no text.
  always_comb begin
    skipped = (base[0] == dlf_pkg::MARK_DELETED) ||
              (attributes == dlf_pkg::ATTR_LONG_NAME) ||
              ((attributes & dlf_pkg::ATTR_VOLUME) != 8'd0) ||
              ((base[0] == dlf_pkg::CHAR_DOT) &&
               ((base[1] == dlf_pkg::CHAR_SPACE) ||
                ((base[1] == dlf_pkg::CHAR_DOT) && (base[2] == dlf_pkg::CHAR_SPACE))));
  end

  // Trimmed lengths: one past the last non-blank byte.
  always_comb begin
    base_len = 5'd0;
    ext_end  = 5'd0;
    for (int i = 0; i < 8; i++) begin
      if (base[i] != dlf_pkg::CHAR_SPACE) begin
        base_len = 5'(i + 1);
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (ext[j] != dlf_pkg::CHAR_SPACE) begin
        ext_end = 5'(j + 1);
      end
    end
  end

  assign has_ext  = ext_end != 5'd0;
  assign ext_stop = base_len + 5'd1 + ext_end;
  assign dir_pos  = has_ext ? ext_stop : base_len;
  assign nl_pos   = dir_pos + {4'd0, is_dir};

  // Each text slot picks its byte from the positions worked out above.
  always_comb begin
    logic [4:0] kk;
    logic [4:0] off;
    entry.start  = start_listing;
    entry.is_end = base[0] == dlf_pkg::MARK_END;
    for (int k = 0; k < dlf_pkg::MAX_CHARS; k++) begin
      kk  = 5'(k);
      off = kk - base_len - 5'd1;
      if (kk < base_len) begin
        entry.chars[k] = base[kk[2:0]];
      end else if (has_ext && (kk == base_len)) begin
        entry.chars[k] = dlf_pkg::CHAR_DOT;
      end else if (has_ext && (kk < ext_stop)) begin
        entry.chars[k] = ext[off[1:0]];
      end else if (is_dir && (kk == dir_pos)) begin
        entry.chars[k] = dlf_pkg::CHAR_SLASH;
      end else begin
        entry.chars[k] = dlf_pkg::CHAR_NEWLINE;
      end
    end
    if (entry.is_end || skipped) begin
      entry.len = '0;
    end else begin
      entry.len = dlf_pkg::LEN_W'(nl_pos + 5'd1);
    end
  end

endmodule
`default_nettype wire

/* src/dlf_emit.sv */
// Byte emitter: counters, one text byte per cycle unless stalled, result register.
`default_nettype none
module dlf_emit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 entry_valid,
  input  wire dlf_pkg::dlf_entry_t  entry,
  output logic                      entry_take,
  input  wire logic [31:0]          skip_bytes,
  input  wire logic [31:0]          buffer_capacity,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output dlf_pkg::dlf_result_t      result
);

  localparam int CW = dlf_pkg::CMP_W;
  localparam int NW = dlf_pkg::CNT_W;

  dlf_pkg::dlf_entry_t             work;
  logic                            work_valid;
  logic [dlf_pkg::IDX_W-1:0]       idx;
  logic [NW-1:0]                   text_position;
  logic [NW-1:0]                   written_count;
  logic                            finished;

  logic [NW-1:0]                   text_position_next;
  logic [NW-1:0]                   written_count_next;
  logic                            finished_next;
  logic                            step;
  logic                            final_step;
  logic                            emit;
  dlf_pkg::dlf_result_t            res_next;
  logic                            at_tail;
  logic [NW-1:0]                   tp_inc;

  assign step    = work_valid && (!res_valid || res_ready);
  assign at_tail = ({1'b0, idx} + 5'd1) == {1'b0, work.len};
  assign tp_inc  = (text_position != dlf_pkg::CNT_MAX) ? text_position + 1'b1 : text_position;

  // One step of the current entry against the listing counters.
  always_comb begin
    text_position_next = text_position;
    written_count_next = written_count;
    finished_next      = finished;
    final_step         = 1'b0;
    emit               = 1'b0;
    res_next.kind       = dlf_pkg::KIND_TEXT;
    res_next.text_byte  = 8'd0;
    res_next.byte_index = 32'(CW'(written_count));
    res_next.last       = 1'b1;
    if (step) begin
      if (finished) begin
        final_step = 1'b1;
      end else if (work.is_end) begin
        emit          = 1'b1;
        res_next.kind = dlf_pkg::KIND_END;
        finished_next = 1'b1;
        final_step    = 1'b1;
      end else if (CW'(text_position) >= CW'(skip_bytes)) begin
        emit = 1'b1;
        if ((CW'(written_count) >= CW'(buffer_capacity)) ||
            (written_count == dlf_pkg::CNT_MAX)) begin
          res_next.kind = dlf_pkg::KIND_FULL;
          finished_next = 1'b1;
          final_step    = 1'b1;
        end else begin
          res_next.text_byte = work.chars[idx];
          res_next.last      = at_tail;
          written_count_next = written_count + 1'b1;
          text_position_next = tp_inc;
          final_step         = at_tail;
        end
      end else begin
        text_position_next = tp_inc;
        final_step         = at_tail;
      end
    end
  end

  assign entry_take = entry_valid && (!work_valid || (step && final_step));

  // Work register and listing counters; a new listing clears them on load.
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid    <= 1'b0;
      idx           <= '0;
      text_position <= '0;
      written_count <= '0;
      finished      <= 1'b0;
    end else begin
      if (entry_take && entry.start) begin
        text_position <= '0;
        written_count <= '0;
        finished      <= 1'b0;
      end else begin
        text_position <= text_position_next;
        written_count <= written_count_next;
        finished      <= finished_next;
      end
      if (entry_take) begin
        work_valid <= entry.is_end || (entry.len != '0);
        idx        <= '0;
      end else if (step && final_step) begin
        work_valid <= 1'b0;
      end else if (step) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Entry payload needs no reset.
  always_ff @(posedge clk) begin
    if (entry_take) begin
      work <= entry;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire

/* src/dir_entry_listing_formatter.sv */
// Top level of the directory entry listing formatter.
//
//   Channel  Direction  Fields
//   s_*      in         tuser: start_listing; tdata: name_base, name_ext, attributes
//   m_*      out        tuser: kind; tdata: text_byte, byte_index; tlast: last
//   wr_*     in         wr_index selects skip_bytes or buffer_capacity
//
// An entry is held in the input register, then the emitter steps through its
// text bytes in order through its single byte path. Skipped entries are dropped
// when the emitter takes them. Reset is synchronous and clears the valid flags,
// the counters and the configuration registers. A stalled output holds the emitter;
// input beats are still taken into the input register while it is free.
`default_nettype none
module dir_entry_listing_formatter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,   // name_base[63:0], name_ext[87:64], attributes[95:88]
  input  wire logic        s_tuser,   // start_listing
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // text_byte[7:0], byte_index[39:8]
  output logic [1:0]       m_tuser,   // kind
  output logic             m_tlast,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [31:0] wr_data
);

  logic                 in_valid;
  logic [95:0]          in_data;
  logic                 in_start;
  logic [31:0]          skip_bytes;
  logic [31:0]          buffer_capacity;
  logic                 entry_take;
  dlf_pkg::dlf_entry_t  entry;
  dlf_pkg::dlf_result_t result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_bytes      <= dlf_pkg::SKIP_BYTES_RESET;
      buffer_capacity <= dlf_pkg::BUFFER_CAPACITY_RESET;
    end else if (wr_en) begin
      case (wr_index)
        dlf_pkg::REG_SKIP_BYTES:      skip_bytes      <= wr_data;
        dlf_pkg::REG_BUFFER_CAPACITY: buffer_capacity <= wr_data;
        default: ;
      endcase
    end
  end

  // Input register: free when empty or when its entry moves on.
  assign s_tready = !in_valid || entry_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  dlf_decode u_decode (
    .start_listing (in_start),
    .name_base     (in_data[63:0]),
    .name_ext      (in_data[87:64]),
    .attributes    (in_data[95:88]),
    .entry         (entry)
  );

  dlf_emit u_emit (
    .clk             (clk),
    .rst             (rst),
    .entry_valid     (in_valid),
    .entry           (entry),
    .entry_take      (entry_take),
    .skip_bytes      (skip_bytes),
    .buffer_capacity (buffer_capacity),
    .res_valid       (m_tvalid),
    .res_ready       (m_tready),
    .result          (result)
  );

  assign m_tdata = {result.byte_index, result.text_byte};
  assign m_tuser = result.kind;
  assign m_tlast = result.last;

endmodule
`default_nettype wire
